>>> hdl/fcbf_pkg.sv
// Shared types, constants and the helper function of the flow-controlled byte FIFO.
`default_nettype none

package fcbf_pkg;

    // Buffer geometry.
    localparam int DEPTH   = 64;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int COUNT_W = 7;
    localparam int DATA_W  = 8;
    localparam int TOTAL_W = 64;

    localparam logic [COUNT_W-1:0] DEPTH_COUNT = COUNT_W'(DEPTH);
    localparam logic [COUNT_W-1:0] CALL_MAX    = '1;
    localparam logic [COUNT_W-1:0] CAP_RESET   = 7'd64;
    localparam logic [ADDR_W:0]    ONE_STEP    = (ADDR_W+1)'(1);

    // Request codes carried in the input tuser field.
    typedef enum logic [2:0] {
        REQ_WRITE = 3'd0,
        REQ_READ  = 3'd1,
        REQ_PEEK  = 3'd2,
        REQ_POP   = 3'd3,
        REQ_END   = 3'd4
    } req_type_t;

    // Controller states.
    typedef enum logic {
        ST_IDLE,
        ST_STREAM
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic               load_write;
        logic               load_status;
        logic               load_byte;
        logic               byte_last;
        logic               byte_remove;
        logic               start_rd;
        logic               issue_rd;
        logic               do_pop;
        logic               do_end;
        logic [COUNT_W-1:0] pop_len;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [COUNT_W-1:0] fill;
        logic               out_free;
    } dp_status_t;

    // Adds an offset of at most DEPTH to a buffer index and wraps it around the buffer.
    function automatic logic [ADDR_W-1:0] wrap_add(logic [ADDR_W-1:0] base,
                                                   logic [ADDR_W:0] offset);
        logic [ADDR_W:0] sum;
        sum = {1'b0, base} + offset;
        if (sum >= (ADDR_W+1)'(DEPTH)) begin
            sum = sum - (ADDR_W+1)'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> hdl/fcbf_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module fcbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port; the read data holds while rd_en is low.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/fcbf_ctrl.sv
// Controller state machine that sequences requests and read or peek streams.
`default_nettype none

module fcbf_ctrl (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [2:0]                    req_code,
    input  wire logic [fcbf_pkg::COUNT_W-1:0]  req_length,
    input  wire fcbf_pkg::dp_status_t          status,
    output fcbf_pkg::dp_cmd_t                  cmd
);

    import fcbf_pkg::*;

    state_t             state_reg, state_next;
    logic [COUNT_W-1:0] issue_left_reg, issue_left_next;
    logic [COUNT_W-1:0] load_left_reg, load_left_next;
    logic               pending_reg, pending_next;
    logic               remove_reg, remove_next;
    logic [COUNT_W-1:0] clamp_len;
    logic               do_load;
    logic               do_issue;
    req_type_t          req;

    assign req       = req_type_t'(req_code);
    assign clamp_len = (req_length < status.fill) ? req_length : status.fill;

    // State and counter registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            issue_left_reg <= '0;
            load_left_reg  <= '0;
            pending_reg    <= 1'b0;
            remove_reg     <= 1'b0;
        end else begin
            state_reg      <= state_next;
            issue_left_reg <= issue_left_next;
            load_left_reg  <= load_left_next;
            pending_reg    <= pending_next;
            remove_reg     <= remove_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next      = state_reg;
        issue_left_next = issue_left_reg;
        load_left_next  = load_left_reg;
        pending_next    = pending_reg;
        remove_next     = remove_reg;
        in_ready        = 1'b0;
        cmd             = '0;
        do_load         = 1'b0;
        do_issue        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                in_ready = status.out_free;
                if (in_valid && status.out_free) begin
                    unique case (req) inside
                        REQ_WRITE: begin
                            cmd.load_write = 1'b1;
                        end
                        REQ_READ, REQ_PEEK: begin
                            if (clamp_len == '0) begin
                                cmd.load_status = 1'b1;
                            end else begin
                                cmd.start_rd    = 1'b1;
                                issue_left_next = clamp_len - 1'b1;
                                load_left_next  = clamp_len;
                                pending_next    = 1'b1;
                                remove_next     = (req == REQ_READ);
                                state_next      = ST_STREAM;
                            end
                        end
                        REQ_POP: begin
                            cmd.do_pop      = 1'b1;
                            cmd.pop_len     = clamp_len;
                            cmd.load_status = 1'b1;
                        end
                        REQ_END: begin
                            cmd.do_end      = 1'b1;
                            cmd.load_status = 1'b1;
                        end
                        default: begin
                            cmd.load_status = 1'b1;
                        end
                    endcase
                end
            end
            ST_STREAM: begin
                // Hand the fetched byte to the output, and fetch the next one in the same cycle.
                do_load         = pending_reg && status.out_free;
                do_issue        = (issue_left_reg != '0) && (!pending_reg || do_load);
                cmd.load_byte   = do_load;
                cmd.byte_last   = (load_left_reg == 7'd1);
                cmd.byte_remove = remove_reg;
                cmd.issue_rd    = do_issue;
                pending_next    = do_issue || (pending_reg && !do_load);
                if (do_issue) begin
                    issue_left_next = issue_left_reg - 1'b1;
                end
                if (do_load) begin
                    load_left_next = load_left_reg - 1'b1;
                    if (load_left_reg == 7'd1) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/fcbf_dp.sv
// Datapath: buffer memory, pointers, counters, totals and the output register.
`default_nettype none

module fcbf_dp (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire fcbf_pkg::dp_cmd_t             cmd,
    input  wire logic [fcbf_pkg::DATA_W-1:0]   wr_byte,
    input  wire logic                          wr_last,
    input  wire logic                          cfg_wr_en,
    input  wire logic [fcbf_pkg::COUNT_W-1:0]  cfg_wr_data,
    output fcbf_pkg::dp_status_t               status,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [fcbf_pkg::DATA_W-1:0]        out_byte,
    output logic                               byte_valid,
    output logic                               run_last,
    output logic                               write_accepted,
    output logic [fcbf_pkg::COUNT_W-1:0]       call_accepted_count,
    output logic [fcbf_pkg::COUNT_W-1:0]       buffered_count,
    output logic [fcbf_pkg::COUNT_W-1:0]       space_left,
    output logic [fcbf_pkg::TOTAL_W-1:0]       total_written,
    output logic [fcbf_pkg::TOTAL_W-1:0]       total_read,
    output logic                               ended_flag,
    output logic                               eof_flag
);

    import fcbf_pkg::*;

    // Buffer state.
    logic [ADDR_W-1:0]  head_reg, head_next;
    logic [ADDR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0] fill_reg, fill_next;
    logic               closed_reg, closed_next;
    logic [TOTAL_W-1:0] wtotal_reg, wtotal_next;
    logic [TOTAL_W-1:0] rtotal_reg, rtotal_next;
    logic [COUNT_W-1:0] call_reg, call_next;
    logic [COUNT_W-1:0] cap_reg;

    // Output register.
    logic               out_valid_reg;
    logic [DATA_W-1:0]  out_byte_reg;
    logic               byte_valid_reg;
    logic               last_reg;
    logic               acc_reg;
    logic [COUNT_W-1:0] cnt_reg;
    logic [COUNT_W-1:0] buf_reg;
    logic [COUNT_W-1:0] space_reg;
    logic [TOTAL_W-1:0] wtotal_out_reg;
    logic [TOTAL_W-1:0] rtotal_out_reg;
    logic               ended_reg;
    logic               eof_reg;

    logic [COUNT_W-1:0] eff_cap;
    logic               accept_byte;
    logic [COUNT_W-1:0] call_inc;
    logic               out_load;
    logic               ram_we;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [DATA_W-1:0]  ram_rdata;

    assign eff_cap     = (cap_reg > DEPTH_COUNT) ? DEPTH_COUNT : cap_reg;
    assign accept_byte = !closed_reg && (fill_reg < eff_cap);
    assign call_inc    = (accept_byte && call_reg != CALL_MAX) ? call_reg + 1'b1 : call_reg;
    assign out_load    = cmd.load_write || cmd.load_status || cmd.load_byte;

    // Memory ports: writes land behind the last buffered byte, streams read from head, then rd_ptr.
    assign ram_we    = cmd.load_write && accept_byte;
    assign ram_waddr = wrap_add(head_reg, fill_reg[ADDR_W:0]);
    assign ram_re    = cmd.start_rd || cmd.issue_rd;
    assign ram_raddr = cmd.start_rd ? head_reg : rd_ptr_reg;

    fcbf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (wr_byte),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Next buffer state for the commanded operation.
    always_comb begin
        head_next   = head_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        closed_next = closed_reg;
        wtotal_next = wtotal_reg;
        rtotal_next = rtotal_reg;
        call_next   = call_reg;

        if (cmd.load_write) begin
            if (accept_byte) begin
                fill_next   = fill_reg + 1'b1;
                wtotal_next = wtotal_reg + 1'b1;
            end
            call_next = wr_last ? '0 : call_inc;
        end
        if (cmd.load_byte && cmd.byte_remove) begin
            head_next   = wrap_add(head_reg, ONE_STEP);
            fill_next   = fill_reg - 1'b1;
            rtotal_next = rtotal_reg + 1'b1;
        end
        if (cmd.do_pop) begin
            head_next   = wrap_add(head_reg, cmd.pop_len[ADDR_W:0]);
            fill_next   = fill_reg - cmd.pop_len;
            rtotal_next = rtotal_reg + TOTAL_W'(cmd.pop_len);
        end
        if (cmd.do_end) begin
            closed_next = 1'b1;
        end
        if (cmd.start_rd) begin
            rd_ptr_next = wrap_add(head_reg, ONE_STEP);
        end else if (cmd.issue_rd) begin
            rd_ptr_next = wrap_add(rd_ptr_reg, ONE_STEP);
        end
    end

    // Buffer state and configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg   <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
            closed_reg <= 1'b0;
            wtotal_reg <= '0;
            rtotal_reg <= '0;
            call_reg   <= '0;
            cap_reg    <= CAP_RESET;
        end else begin
            head_reg   <= head_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
            closed_reg <= closed_next;
            wtotal_reg <= wtotal_next;
            rtotal_reg <= rtotal_next;
            call_reg   <= call_next;
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    // Output valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload, with status taken after this result's effect.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_byte_reg   <= cmd.load_byte ? ram_rdata : '0;
            byte_valid_reg <= cmd.load_byte;
            last_reg       <= cmd.load_byte ? cmd.byte_last : 1'b1;
            acc_reg        <= cmd.load_write && accept_byte;
            cnt_reg        <= cmd.load_write ? call_inc : '0;
            buf_reg        <= fill_next;
            space_reg      <= (eff_cap > fill_next) ? eff_cap - fill_next : '0;
            wtotal_out_reg <= wtotal_next;
            rtotal_out_reg <= rtotal_next;
            ended_reg      <= closed_next;
            eof_reg        <= closed_next && (fill_next == '0);
        end
    end

    assign status.fill     = fill_reg;
    assign status.out_free = !out_valid_reg || m_ready;

    assign m_valid             = out_valid_reg;
    assign out_byte            = out_byte_reg;
    assign byte_valid          = byte_valid_reg;
    assign run_last            = last_reg;
    assign write_accepted      = acc_reg;
    assign call_accepted_count = cnt_reg;
    assign buffered_count      = buf_reg;
    assign space_left          = space_reg;
    assign total_written       = wtotal_out_reg;
    assign total_read          = rtotal_out_reg;
    assign ended_flag          = ended_reg;
    assign eof_flag            = eof_reg;

endmodule

`default_nettype wire

>>> hdl/flow_controlled_byte_fifo.sv
// Top level of the flow-controlled byte FIFO: stream ports, controller and datapath.
`default_nettype none

// A bounded byte FIFO of 64 entries with flow control and an end-of-input flag. Each
// input transfer is one request (write byte, read, peek, pop, end input); each result
// transfer carries one returned byte or one status report, with tlast on the final
// result of the request. Write, pop, end-input and unknown requests give one result each.
// A read or peek of n bytes, clamped to the buffered count, gives n results (one status
// result if n is zero): an access to the registered read port of the buffer memory, then
// one byte per cycle as that port streams, as long as the result side does not stall. A new
// request is taken only while the output register is empty or is handing its result on
// in the same cycle, so a stalled result side holds off the request side. The
// buffer memory needs no clearing pass after reset; only written entries are ever read.
// The capacity register (reset 64, values above 64 act as 64) may only be written while
// the block is idle.
module flow_controlled_byte_fifo (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // Configuration: capacity register.
    input  wire logic         cfg_wr_en,
    input  wire logic [6:0]   cfg_wr_data,
    // Request channel.
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [15:0]  s_axis_tdata,   // [7:0] wr_byte, [14:8] req_length, [15] zero
    input  wire logic         s_axis_tlast,   // wr_last
    input  wire logic [2:0]   s_axis_tuser,   // [2:0] req_type
    // Result channel.
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [159:0]      m_axis_tdata,   // [7:0] out_byte, [8] write_accepted,
                                              // [15:9] call_accepted_count,
                                              // [22:16] buffered_count, [29:23] space_left,
                                              // [93:30] total_written, [157:94] total_read,
                                              // [158] ended_flag, [159] eof_flag
    output logic              m_axis_tlast,   // run_last
    output logic              m_axis_tuser    // byte_valid
);

    import fcbf_pkg::*;

    dp_cmd_t            cmd;
    dp_status_t         status;
    logic [DATA_W-1:0]  out_byte;
    logic               write_accepted;
    logic [COUNT_W-1:0] call_accepted_count;
    logic [COUNT_W-1:0] buffered_count;
    logic [COUNT_W-1:0] space_left;
    logic [TOTAL_W-1:0] total_written;
    logic [TOTAL_W-1:0] total_read;
    logic               ended_flag;
    logic               eof_flag;

    fcbf_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .req_code   (s_axis_tuser),
        .req_length (s_axis_tdata[14:8]),
        .status     (status),
        .cmd        (cmd)
    );

    fcbf_dp u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .wr_byte             (s_axis_tdata[7:0]),
        .wr_last             (s_axis_tlast),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_data         (cfg_wr_data),
        .status              (status),
        .m_valid             (m_axis_tvalid),
        .m_ready             (m_axis_tready),
        .out_byte            (out_byte),
        .byte_valid          (m_axis_tuser),
        .run_last            (m_axis_tlast),
        .write_accepted      (write_accepted),
        .call_accepted_count (call_accepted_count),
        .buffered_count      (buffered_count),
        .space_left          (space_left),
        .total_written       (total_written),
        .total_read          (total_read),
        .ended_flag          (ended_flag),
        .eof_flag            (eof_flag)
    );

    // Pack the result fields from the lowest bit up.
    assign m_axis_tdata = {eof_flag, ended_flag, total_read, total_written, space_left,
                           buffered_count, call_accepted_count, write_accepted, out_byte};

    // Once a stream starts, no request is taken until its last byte is out.
    a_stream_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start_rd |=> !s_axis_tready)
        else $error("request taken while a read or peek stream was running");

    // A result never carries both a returned byte and a write acknowledgement.
    a_byte_or_write: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> !m_axis_tdata[8])
        else $error("result marks both a returned byte and an accepted write");

    // The eof flag only shows with input ended and an empty buffer.
    a_eof_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[159] |-> m_axis_tdata[158] && (m_axis_tdata[22:16] == '0))
        else $error("eof reported with input open or bytes still buffered");

endmodule

`default_nettype wire

>>> bench/flow_controlled_byte_fifo_test.sv
// Self-checking testbench for the flow-controlled byte FIFO with a built-in predictor.
`default_nettype none

module flow_controlled_byte_fifo_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fcbf_pkg::*;

    // Request codes outside the defined set, which the block only answers with a status.
    localparam logic [2:0] REQ_RESERVED_FIRST = 3'd5;
    localparam logic [2:0] REQ_RESERVED_LAST  = 3'd7;
    localparam int         CALL_LIMIT         = 127;

    // One result transfer, split into its fields.
    typedef struct packed {
        logic [DATA_W-1:0]  out_byte;
        logic               byte_valid;
        logic               run_last;
        logic               write_accepted;
        logic [COUNT_W-1:0] call_count;
        logic [COUNT_W-1:0] buffered;
        logic [COUNT_W-1:0] space;
        logic [TOTAL_W-1:0] total_written;
        logic [TOTAL_W-1:0] total_read;
        logic               ended;
        logic               eof;
    } fifo_result_t;

    logic          aclk;
    logic          aresetn;
    logic          cfg_wr_en;
    logic [6:0]    cfg_wr_data;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [15:0]   s_axis_tdata;
    logic          s_axis_tlast;
    logic [2:0]    s_axis_tuser;
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [159:0]  m_axis_tdata;
    logic          m_axis_tlast;
    logic          m_axis_tuser;

    // Predicted FIFO contents and status.
    logic [DATA_W-1:0]  fifo_bytes [DEPTH];
    logic [ADDR_W-1:0]  fifo_head;
    int unsigned        fifo_fill;
    bit                 fifo_closed;
    logic [TOTAL_W-1:0] model_written_total;
    logic [TOTAL_W-1:0] model_read_total;
    int unsigned        call_bytes;
    logic [COUNT_W-1:0] capacity_reg;

    fifo_result_t pending_results [$];
    int           error_count;
    int           s_idle_pct;
    int           m_idle_pct;

    flow_controlled_byte_fifo u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 100 MHz clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Capacity above the buffer depth behaves as the depth.
    function automatic int unsigned usable_capacity();
        return (capacity_reg > DEPTH) ? DEPTH : capacity_reg;
    endfunction

    // Queues one expected result, with the status taken from the current predicted state.
    function automatic void push_result(logic [DATA_W-1:0] data, logic valid, logic last,
                                        logic accepted, int unsigned count);
        fifo_result_t r;
        int unsigned  cap;
        cap              = usable_capacity();
        r.out_byte       = data;
        r.byte_valid     = valid;
        r.run_last       = last;
        r.write_accepted = accepted;
        r.call_count     = COUNT_W'(count);
        r.buffered       = COUNT_W'(fifo_fill);
        r.space          = (cap > fifo_fill) ? COUNT_W'(cap - fifo_fill) : '0;
        r.total_written  = model_written_total;
        r.total_read     = model_read_total;
        r.ended          = fifo_closed;
        r.eof            = fifo_closed && (fifo_fill == 0);
        pending_results.insert(pending_results.size(), r);
    endfunction

    function automatic void remove_front_byte();
        fifo_head        = ADDR_W'(fifo_head + 1);
        fifo_fill        = fifo_fill - 1;
        model_read_total = model_read_total + 1;
    endfunction

    // Advances the predicted FIFO by one accepted request and queues its results.
    function automatic void predict_request(logic [2:0] req, logic [DATA_W-1:0] wr_byte,
                                            logic wr_last, logic [COUNT_W-1:0] req_len);
        int unsigned       n;
        logic              accepted;
        logic [DATA_W-1:0] data;
        n = (req_len < fifo_fill) ? req_len : fifo_fill;
        case (req)
            REQ_WRITE: begin
                accepted = !fifo_closed && (fifo_fill < usable_capacity());
                if (accepted) begin
                    fifo_bytes[ADDR_W'(fifo_head + fifo_fill)] = wr_byte;
                    fifo_fill           = fifo_fill + 1;
                    model_written_total = model_written_total + 1;
                    if (call_bytes < CALL_LIMIT) begin
                        call_bytes = call_bytes + 1;
                    end
                end
                push_result('0, 1'b0, 1'b1, accepted, call_bytes);
                if (wr_last) begin
                    call_bytes = 0;
                end
            end
            REQ_READ, REQ_PEEK: begin
                if (n == 0) begin
                    push_result('0, 1'b0, 1'b1, 1'b0, 0);
                end
                for (int i = 0; i < n; i++) begin
                    if (req == REQ_READ) begin
                        data = fifo_bytes[fifo_head];
                        remove_front_byte();
                    end else begin
                        data = fifo_bytes[ADDR_W'(fifo_head + i)];
                    end
                    push_result(data, 1'b1, (i == n - 1), 1'b0, 0);
                end
            end
            REQ_POP: begin
                for (int i = 0; i < n; i++) begin
                    remove_front_byte();
                end
                push_result('0, 1'b0, 1'b1, 1'b0, 0);
            end
            REQ_END: begin
                fifo_closed = 1'b1;
                push_result('0, 1'b0, 1'b1, 1'b0, 0);
            end
            default: begin
                push_result('0, 1'b0, 1'b1, 1'b0, 0);
            end
        endcase
    endfunction

    task automatic compare_field(string name, logic [TOTAL_W-1:0] expected,
                                 logic [TOTAL_W-1:0] actual);
        if (expected !== actual) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, expected, actual);
            error_count++;
        end
    endtask

    // Result side: random back-pressure and a check of every transfer.
    always @(posedge aclk) begin
        fifo_result_t want;
        fifo_result_t got;
        m_axis_tready <= ($urandom_range(99) >= m_idle_pct);
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.out_byte       = m_axis_tdata[7:0];
            got.write_accepted = m_axis_tdata[8];
            got.call_count     = m_axis_tdata[15:9];
            got.buffered       = m_axis_tdata[22:16];
            got.space          = m_axis_tdata[29:23];
            got.total_written  = m_axis_tdata[93:30];
            got.total_read     = m_axis_tdata[157:94];
            got.ended          = m_axis_tdata[158];
            got.eof            = m_axis_tdata[159];
            got.run_last       = m_axis_tlast;
            got.byte_valid     = m_axis_tuser;
            if (pending_results.size() == 0) begin
                $error("result transfer arrived with nothing expected");
                error_count++;
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                compare_field("out_byte", want.out_byte, got.out_byte);
                compare_field("byte_valid", want.byte_valid, got.byte_valid);
                compare_field("run_last", want.run_last, got.run_last);
                compare_field("write_accepted", want.write_accepted, got.write_accepted);
                compare_field("call_accepted_count", want.call_count, got.call_count);
                compare_field("buffered_count", want.buffered, got.buffered);
                compare_field("space_left", want.space, got.space);
                compare_field("total_written", want.total_written, got.total_written);
                compare_field("total_read", want.total_read, got.total_read);
                compare_field("ended_flag", want.ended, got.ended);
                compare_field("eof_flag", want.eof, got.eof);
            end
        end
    end

    // Sends one request after an optional random gap and predicts it once it is accepted.
    // The valid stays high after the transfer so that back-to-back requests need no gap.
    task automatic send_request(logic [2:0] req, logic [DATA_W-1:0] wr_byte, logic wr_last,
                                logic [COUNT_W-1:0] req_len);
        if ($urandom_range(99) < s_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < s_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, req_len, wr_byte};
        s_axis_tlast  <= wr_last;
        s_axis_tuser  <= req;
        do @(posedge aclk); while (!s_axis_tready);
        predict_request(req, wr_byte, wr_last, req_len);
    endtask

    // Holds the request side until every expected result has been seen.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    // Writes the capacity register once the block is idle.
    task automatic set_capacity(logic [COUNT_W-1:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        capacity_reg  = value;
    endtask

    // One write call of random bytes, optionally closed by a last mark.
    task automatic write_call(int count, bit close_call);
        for (int i = 0; i < count; i++) begin
            send_request(REQ_WRITE, 8'($urandom_range(255)), close_call && (i == count - 1),
                         7'($urandom_range(127)));
        end
    endtask

    // Mostly short lengths, with a few reaching the depth and the full field range.
    function automatic logic [COUNT_W-1:0] random_length();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 70) begin
            return COUNT_W'($urandom_range(16));
        end else if (pick < 90) begin
            return COUNT_W'($urandom_range(DEPTH));
        end
        return COUNT_W'($urandom_range(127));
    endfunction

    // Byte extremes, call counts, peek, zero-length and clamped reads, empty buffer.
    task automatic test_write_read_peek();
        send_request(REQ_WRITE, 8'h00, 1'b0, 7'd0);
        send_request(REQ_WRITE, 8'hFF, 1'b0, 7'd127);
        send_request(REQ_WRITE, 8'hA5, 1'b1, 7'd0);
        send_request(REQ_PEEK, 8'hFF, 1'b1, 7'd2);
        send_request(REQ_PEEK, 8'h00, 1'b0, 7'd0);
        send_request(REQ_READ, 8'h00, 1'b0, 7'd0);
        send_request(REQ_READ, 8'h00, 1'b0, 7'd127);
        send_request(REQ_READ, 8'h00, 1'b0, 7'd5);
        send_request(REQ_PEEK, 8'h00, 1'b0, 7'd3);
    endtask

    // Pop with zero, partial and clamped lengths, then the reserved request codes.
    task automatic test_pop_and_reserved();
        write_call(4, 1'b1);
        send_request(REQ_POP, 8'h00, 1'b0, 7'd2);
        send_request(REQ_POP, 8'h00, 1'b0, 7'd0);
        send_request(REQ_POP, 8'h00, 1'b0, 7'd100);
        send_request(REQ_READ, 8'h00, 1'b0, 7'd1);
        for (int code = REQ_RESERVED_FIRST; code <= REQ_RESERVED_LAST; code++) begin
            send_request(3'(code), 8'($urandom_range(255)), 1'($urandom_range(1)),
                         7'($urandom_range(127)));
        end
    endtask

    // Capacities of one and zero: rejected bytes, and the call count closing on a reject.
    task automatic test_small_capacities();
        set_capacity(7'd1);
        write_call(2, 1'b1);
        send_request(REQ_READ, 8'h00, 1'b0, 7'd1);
        set_capacity(7'd0);
        write_call(2, 1'b1);
        send_request(REQ_PEEK, 8'h00, 1'b0, 7'd4);
    endtask

    // Full buffer with capacity above the depth, capacity lowered under the fill, and the
    // call count saturating over a long write call that spans two buffer loads.
    task automatic test_full_buffer_and_call_count();
        set_capacity(7'd127);
        write_call(DEPTH + 1, 1'b0);
        set_capacity(7'd10);
        write_call(1, 1'b0);
        send_request(REQ_PEEK, 8'h00, 1'b0, 7'd64);
        send_request(REQ_READ, 8'h00, 1'b0, 7'd64);
        set_capacity(CAP_RESET);
        write_call(DEPTH, 1'b0);
        write_call(1, 1'b1);
        send_request(REQ_READ, 8'h00, 1'b0, 7'd64);
        write_call(1, 1'b1);
        send_request(REQ_READ, 8'h00, 1'b0, 7'd1);
    endtask

    // Mostly well-formed write calls and reads, with stray marks and reserved codes mixed in.
    task automatic run_random_traffic(int items);
        int sent;
        int pick;
        int burst;
        sent = 0;
        while (sent < items) begin
            pick = $urandom_range(99);
            if ($urandom_range(29) == 0) begin
                drain_results();
            end
            if (pick < 45) begin
                burst = $urandom_range(1, 8);
                for (int i = 0; i < burst; i++) begin
                    send_request(REQ_WRITE, 8'($urandom_range(255)),
                                 (i == burst - 1) ? ($urandom_range(9) != 0)
                                                  : ($urandom_range(19) == 0),
                                 7'($urandom_range(127)));
                end
                sent += burst;
            end else begin
                if (pick < 65) begin
                    send_request(REQ_READ, 8'($urandom_range(255)), 1'($urandom_range(1)),
                                 random_length());
                end else if (pick < 82) begin
                    send_request(REQ_PEEK, 8'($urandom_range(255)), 1'($urandom_range(1)),
                                 random_length());
                end else if (pick < 95) begin
                    send_request(REQ_POP, 8'($urandom_range(255)), 1'($urandom_range(1)),
                                 random_length());
                end else begin
                    send_request(3'($urandom_range(REQ_RESERVED_FIRST, REQ_RESERVED_LAST)),
                                 8'($urandom_range(255)), 1'($urandom_range(1)),
                                 7'($urandom_range(127)));
                end
                sent++;
            end
        end
    endtask

    // End of input: writes rejected, the flag is sticky, eof once the buffer drains.
    task automatic test_end_of_input();
        set_capacity(CAP_RESET);
        write_call(3, 1'b1);
        send_request(REQ_END, 8'($urandom_range(255)), 1'b0, 7'($urandom_range(127)));
        write_call(2, 1'b1);
        send_request(REQ_END, 8'($urandom_range(255)), 1'b1, 7'($urandom_range(127)));
        send_request(REQ_PEEK, 8'h00, 1'b0, 7'd10);
        send_request(REQ_READ, 8'h00, 1'b0, 7'd1);
        send_request(REQ_POP, 8'h00, 1'b0, 7'd127);
        send_request(REQ_READ, 8'h00, 1'b0, 7'd4);
        // Any request at all once input has ended.
        for (int i = 0; i < 8; i++) begin
            send_request(3'($urandom_range(7)), 8'($urandom_range(255)),
                         1'($urandom_range(1)), random_length());
        end
    endtask

    // Test sequence.
    initial begin
        aresetn       <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        s_axis_tuser  <= REQ_WRITE;
        m_axis_tready <= 1'b0;
        fifo_head           = '0;
        fifo_fill           = 0;
        fifo_closed         = 1'b0;
        model_written_total = '0;
        model_read_total    = '0;
        call_bytes          = 0;
        capacity_reg        = CAP_RESET;
        error_count         = 0;
        s_idle_pct          = 7;
        m_idle_pct          = 55;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_write_read_peek();
        test_pop_and_reserved();
        test_small_capacities();
        test_full_buffer_and_call_count();

        set_capacity(7'($urandom_range(1, 8)));
        run_random_traffic(10);
        s_idle_pct = 55;
        m_idle_pct = 7;
        set_capacity(7'd127);
        run_random_traffic(10);
        s_idle_pct = 0;
        m_idle_pct = 0;
        set_capacity(7'($urandom_range(9, DEPTH)));
        run_random_traffic(10);

        s_idle_pct = 7;
        m_idle_pct = 55;
        test_end_of_input();

        drain_results();
        repeat (10) @(posedge aclk);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
hdl/fcbf_pkg.sv
hdl/fcbf_ram.sv
hdl/fcbf_ctrl.sv
hdl/fcbf_dp.sv
hdl/flow_controlled_byte_fifo.sv
bench/flow_controlled_byte_fifo_test.sv
